[rtl/light_extinction_radius_top_macros.svh]
// assertion macros for the light extinction radius block
// expects clk and rst in the scope of every use
`ifndef LIGHT_EXTINCTION_RADIUS_TOP_MACROS_SVH
`define LIGHT_EXTINCTION_RADIUS_TOP_MACROS_SVH

// same-cycle implication
`define LER_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LER_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ler_pkg.sv]
// constants and types for the light extinction radius block
// no dependencies
`timescale 1ns / 1ps

package ler_pkg;

  localparam logic [15:0] LUMA_RED   = 16'd13933;
  localparam logic [15:0] LUMA_GREEN = 16'd46871;
  localparam logic [15:0] LUMA_BLUE  = 16'd4732;
  localparam logic [15:0] THR_RESET  = 16'd255;

  localparam int SQ_STEPS  = 50;
  localparam int ROOT_W    = 50;
  localparam int SQ_REM_W  = 52;
  localparam int RAD_W     = 100;
  localparam int DIV_STEPS = 50;
  localparam int DIV_N_W   = 50;
  localparam int DIV_D_W   = 32;
  localparam int LNUM_W    = 49;

  typedef enum logic [1:0] {
    CLS_LIN,
    CLS_QUAD,
    CLS_INF,
    CLS_ZERO
  } cls_t;

endpackage

[rtl/ler_light_if.sv]
// word channels of the light extinction radius block
// uses no package
`timescale 1ns / 1ps

interface ler_light_if;
  logic        valid;
  logic        ready;
  logic [15:0] red_level;
  logic [15:0] green_level;
  logic [15:0] blue_level;
  logic signed [31:0] constant_term;
  logic signed [31:0] linear_term;
  logic signed [31:0] quadratic_term;

  modport source (output valid, red_level, green_level, blue_level, constant_term,
                  linear_term, quadratic_term, input ready);
  modport sink (input valid, red_level, green_level, blue_level, constant_term,
                linear_term, quadratic_term, output ready);
endinterface

interface ler_extent_if;
  logic        valid;
  logic        ready;
  logic [31:0] radius;
  logic        infinite_range;

  modport source (output valid, radius, infinite_range, input ready);
  modport sink (input valid, radius, infinite_range, output ready);
endinterface

[rtl/light_extinction_radius_top.sv]
// light extinction radius pipeline: luminance, discriminant, square root, divider
// depends on ler_pkg, ler_light_if.sv and light_extinction_radius_top_macros.svh
// usage:
//   light (sink): one word per light, rgb level q0.16 and c, b, a coefficients q16.16
//   extent (source): one word per light, radius q16.16 and infinite_range flag
//   cfg_wen / cfg_wdata: writes inverse_threshold, only while no light is in flight
// pipeline: 107 register stages (5 front stages, 50 square root stages, 1 numerator
//   stage, 50 divider stages, 1 output register); the first loads at the accepting edge
// throughput: one light per cycle while light.ready is high; the square root and the
//   divider retire one bit per stage, which sets the depth, not the rate
// reset: all valid bits clear, inverse_threshold returns to 255
// stall: the whole pipeline advances together; a skid register behind the output
//   register catches the word in flight, and light.ready drops only while the
//   skid register is full, so nothing is lost or repeated
`timescale 1ns / 1ps
`include "light_extinction_radius_top_macros.svh"

module light_extinction_radius_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wen,
  input  logic [15:0]         cfg_wdata,
  ler_light_if.sink           light,
  ler_extent_if.source        extent
);

  localparam int SQN = ler_pkg::SQ_STEPS;
  localparam int DVN = ler_pkg::DIV_STEPS;
  localparam int RW  = ler_pkg::SQ_REM_W;
  localparam int TW  = ler_pkg::ROOT_W;
  localparam int XW  = ler_pkg::RAD_W;
  localparam int NW  = ler_pkg::DIV_N_W;
  localparam int DW  = ler_pkg::DIV_D_W;
  localparam int LW  = ler_pkg::LNUM_W;

  logic [15:0] thr;
  logic        en;

  logic              o_valid, s_valid, o_inf, s_inf;
  logic [31:0]       o_radius, s_radius;

  assign en = !s_valid;
  assign light.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= ler_pkg::THR_RESET;
    end else if (cfg_wen) begin
      thr <= cfg_wdata;
    end
  end

  // stage 1: luminance
  logic        v1;
  logic [31:0] lum1;
  logic signed [31:0] c1, b1, a1;
  logic [31:0] lum_c;

  assign lum_c = 32'(light.red_level) * 32'(ler_pkg::LUMA_RED)
               + 32'(light.green_level) * 32'(ler_pkg::LUMA_GREEN)
               + 32'(light.blue_level) * 32'(ler_pkg::LUMA_BLUE);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= light.valid;
    end
    if (en) begin
      lum1 <= lum_c;
      c1   <= light.constant_term;
      b1   <= light.linear_term;
      a1   <= light.quadratic_term;
    end
  end

  // stage 2: scaled intensity k
  logic        v2;
  logic [32:0] k2;
  logic signed [31:0] c2, b2, a2;
  logic [48:0] kp_c;

  assign kp_c = 49'(lum1) * 49'(thr) + 49'(32768);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      k2 <= kp_c[48:16];
      c2 <= c1;
      b2 <= b1;
      a2 <= a1;
    end
  end

  // stage 3: m = k - c and case split
  logic        v3;
  logic signed [34:0] m3;
  logic signed [31:0] b3;
  logic [30:0] a3;
  ler_pkg::cls_t cls3;
  logic signed [34:0] m_c;
  ler_pkg::cls_t cls_c;

  assign m_c = $signed({2'b00, k2}) - 35'(c2);

  always_comb begin
    priority if (a2 == 32'sd0) begin
      if (b2 > 32'sd0) begin
        cls_c = (m_c > 35'sd0) ? ler_pkg::CLS_LIN : ler_pkg::CLS_ZERO;
      end else begin
        cls_c = ler_pkg::CLS_INF;
      end
    end else if (a2 < 32'sd0) begin
      cls_c = ler_pkg::CLS_INF;
    end else begin
      cls_c = ler_pkg::CLS_QUAD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      m3   <= m_c;
      b3   <= b2;
      a3   <= a2[30:0];
      cls3 <= cls_c;
    end
  end

  // stage 4: a*|m| and b*b
  logic        v4;
  logic [64:0] p4;
  logic [63:0] bsq4;
  logic        mneg4;
  logic [LW-1:0] lnum4;
  logic signed [31:0] b4;
  logic [30:0] a4;
  ler_pkg::cls_t cls4;
  logic [33:0] absm_c;
  logic [31:0] absb_c;

  assign absm_c = m3[34] ? 34'(-m3) : 34'(m3);
  assign absb_c = b3[31] ? 32'(-b3) : 32'(b3);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
    if (en) begin
      p4    <= 65'(a3) * 65'(absm_c);
      bsq4  <= 64'(absb_c) * 64'(absb_c);
      mneg4 <= m3[34];
      lnum4 <= {m3[32:0], 16'b0};
      b4    <= b3;
      a4    <= a3;
      cls4  <= cls3;
    end
  end

  // stage 5: discriminant, square root stage 0 registers
  logic          sq_v    [0:SQN];
  ler_pkg::cls_t sq_cls  [0:SQN];
  logic signed [31:0] sq_b [0:SQN];
  logic [30:0]   sq_a    [0:SQN];
  logic [LW-1:0] sq_lnum [0:SQN];
  logic [RW-1:0] sq_rem  [0:SQN];
  logic [TW-1:0] sq_root [0:SQN];
  logic [XW-1:0] sq_x    [0:SQN];

  logic [66:0]   fourp_c, bsq_c, d_c;
  logic          dneg_c;
  ler_pkg::cls_t cls5_c;

  assign fourp_c = {p4, 2'b00};
  assign bsq_c   = 67'(bsq4);
  assign dneg_c  = mneg4 && (bsq_c < fourp_c);
  assign d_c     = mneg4 ? bsq_c - fourp_c : bsq_c + fourp_c;
  assign cls5_c  = (cls4 == ler_pkg::CLS_QUAD && dneg_c) ? ler_pkg::CLS_ZERO : cls4;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= v4;
    end
    if (en) begin
      sq_cls[0]  <= cls5_c;
      sq_b[0]    <= b4;
      sq_a[0]    <= a4;
      sq_lnum[0] <= lnum4;
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_x[0]    <= {1'b0, d_c, 32'b0};
    end
  end

  // square root, one result bit per stage
  for (genvar i = 0; i < SQN; i++) begin : g_sqrt
    logic [RW+1:0] cur, trial;
    logic          ge;

    assign cur   = {sq_rem[i], sq_x[i][XW-1:XW-2]};
    assign trial = {2'b00, sq_root[i], 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[i+1] <= 1'b0;
      end else if (en) begin
        sq_v[i+1] <= sq_v[i];
      end
      if (en) begin
        sq_cls[i+1]  <= sq_cls[i];
        sq_b[i+1]    <= sq_b[i];
        sq_a[i+1]    <= sq_a[i];
        sq_lnum[i+1] <= sq_lnum[i];
        sq_rem[i+1]  <= ge ? RW'(cur - trial) : RW'(cur);
        sq_root[i+1] <= {sq_root[i][TW-2:0], ge};
        sq_x[i+1]    <= {sq_x[i][XW-3:0], 2'b00};
      end
    end
  end

  // numerator and divisor, divider stage 0 registers
  logic          dv_v   [0:DVN];
  ler_pkg::cls_t dv_cls [0:DVN];
  logic [NW-1:0] dv_n   [0:DVN];
  logic [DW-1:0] dv_d   [0:DVN];
  logic [DW-1:0] dv_rem [0:DVN];

  logic signed [51:0] num_c;
  ler_pkg::cls_t      cls6_c;
  logic [NW-1:0]      n6_c;
  logic [DW-1:0]      d6_c;

  assign num_c = $signed({2'b00, sq_root[SQN]})
               - $signed({{4{sq_b[SQN][31]}}, sq_b[SQN], 16'b0});

  always_comb begin
    cls6_c = sq_cls[SQN];
    n6_c   = NW'(sq_lnum[SQN]);
    d6_c   = DW'(sq_b[SQN]);
    unique case (sq_cls[SQN])
      ler_pkg::CLS_QUAD: begin
        n6_c   = num_c[NW-1:0];
        d6_c   = {sq_a[SQN], 1'b0};
        cls6_c = (num_c > 52'sd0) ? ler_pkg::CLS_LIN : ler_pkg::CLS_ZERO;
      end
      ler_pkg::CLS_LIN, ler_pkg::CLS_INF, ler_pkg::CLS_ZERO: begin
        cls6_c = sq_cls[SQN];
      end
      default: cls6_c = sq_cls[SQN];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= sq_v[SQN];
    end
    if (en) begin
      dv_cls[0] <= cls6_c;
      dv_n[0]   <= n6_c;
      dv_d[0]   <= d6_c;
      dv_rem[0] <= '0;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar j = 0; j < DVN; j++) begin : g_div
    logic [DW:0] cur;
    logic        ge;

    assign cur = {dv_rem[j], dv_n[j][NW-1]};
    assign ge  = (cur >= {1'b0, dv_d[j]});

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j+1] <= 1'b0;
      end else if (en) begin
        dv_v[j+1] <= dv_v[j];
      end
      if (en) begin
        dv_cls[j+1] <= dv_cls[j];
        dv_d[j+1]   <= dv_d[j];
        dv_rem[j+1] <= ge ? DW'(cur - {1'b0, dv_d[j]}) : DW'(cur);
        dv_n[j+1]   <= {dv_n[j][NW-2:0], ge};
      end
    end
  end

  // result word
  logic [31:0] rad_c;
  logic        inf_c;

  always_comb begin
    inf_c = 1'b0;
    unique case (dv_cls[DVN])
      ler_pkg::CLS_LIN:  rad_c = (|dv_n[DVN][NW-1:32]) ? '1 : dv_n[DVN][31:0];
      ler_pkg::CLS_INF: begin
        rad_c = '1;
        inf_c = 1'b1;
      end
      ler_pkg::CLS_QUAD, ler_pkg::CLS_ZERO: rad_c = '0;
      default: rad_c = '0;
    endcase
  end

  // output register and skid register
  logic take;
  assign take = o_valid && extent.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      s_valid <= 1'b0;
    end else if (s_valid) begin
      if (take) begin
        o_radius <= s_radius;
        o_inf    <= s_inf;
        s_valid  <= 1'b0;
      end
    end else if (dv_v[DVN]) begin
      if (!o_valid || take) begin
        o_radius <= rad_c;
        o_inf    <= inf_c;
        o_valid  <= 1'b1;
      end else begin
        s_radius <= rad_c;
        s_inf    <= inf_c;
        s_valid  <= 1'b1;
      end
    end else if (take) begin
      o_valid <= 1'b0;
    end
  end

  assign extent.valid          = o_valid;
  assign extent.radius         = o_radius;
  assign extent.infinite_range = o_inf;

  `LER_ASSERT_NOW(a_skid_behind_out, s_valid, o_valid, "skid word without output word")
  `LER_ASSERT_NOW(a_inf_is_max, o_valid && o_inf, o_radius == 32'hFFFF_FFFF, "infinite not max")
  `LER_ASSERT_NEXT(a_accept_enters, light.valid && light.ready, v1, "accepted word dropped")
  `LER_ASSERT_NEXT(a_skid_holds, s_valid && !extent.ready, s_valid && $stable(s_radius), "skid lost")

endmodule

[tb/sv/light_extinction_radius_top_tb.sv]
// self-checking testbench for light_extinction_radius_top: directed lights, register
// settings, back-pressure and random lights checked against an in-bench predictor
// depends on ler_pkg, ler_light_if.sv and the rtl of the block
`timescale 1ns / 1ps

module light_extinction_radius_top_tb;

  localparam int  LIMIT_CYCLES = 400000;
  localparam int  DRAIN_CYCLES = 130;
  localparam logic [31:0] RADIUS_FULL = 32'hFFFFFFFF;

  typedef struct packed {
    logic [31:0] radius;
    logic        infinite_range;
  } extent_t;

  logic clk;
  logic rst;
  logic cfg_wen;
  logic [15:0] cfg_wdata;

  ler_light_if  light ();
  ler_extent_if extent ();

  light_extinction_radius_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .light     (light),
    .extent    (extent)
  );

  logic [15:0] inv_threshold;
  extent_t     pending_extents[$];
  int          mismatch_count;
  int          cycle_count;
  int          light_count;
  int          infinite_count;
  int          saturated_count;
  int          zero_count;
  bit          idle_free;
  int          hold_request;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [63:0] floor_root(logic [127:0] x);
    logic [127:0] res;
    logic [127:0] t;
    res = '0;
    for (int i = 51; i >= 0; i--) begin
      t = res | (128'd1 << i);
      if (t * t <= x) res = t;
    end
    return res[63:0];
  endfunction

  function automatic extent_t predict_extent(logic [15:0] r, logic [15:0] g, logic [15:0] bl,
                                             logic signed [31:0] c, logic signed [31:0] b,
                                             logic signed [31:0] a);
    logic [63:0]  lum;
    logic [63:0]  k;
    longint       m;
    logic [63:0]  q;
    logic [127:0] absb;
    logic [127:0] absm;
    logic [127:0] bsq;
    logic [127:0] fourp;
    logic [127:0] d;
    longint       num;
    extent_t      e;
    lum = 64'(ler_pkg::LUMA_RED) * r + 64'(ler_pkg::LUMA_GREEN) * g
        + 64'(ler_pkg::LUMA_BLUE) * bl;
    k = (lum * 64'(inv_threshold) + 64'd32768) >> 16;
    m = longint'(k) - longint'(c);
    e.radius = '0;
    e.infinite_range = 1'b0;
    if (a == 0) begin
      if (b > 0) begin
        if (m > 0) begin
          q = (64'(m) << 16) / 64'(longint'(b));
          e.radius = (q > 64'(RADIUS_FULL)) ? RADIUS_FULL : q[31:0];
        end
      end else begin
        e.radius = RADIUS_FULL;
        e.infinite_range = 1'b1;
      end
    end else if (a < 0) begin
      e.radius = RADIUS_FULL;
      e.infinite_range = 1'b1;
    end else begin
      absb = 128'((b < 0) ? -longint'(b) : longint'(b));
      absm = 128'((m < 0) ? -m : m);
      bsq = absb * absb;
      fourp = 128'd4 * 128'(longint'(a)) * absm;
      if (m >= 0 || bsq >= fourp) begin
        d = (m >= 0) ? bsq + fourp : bsq - fourp;
        num = longint'(floor_root(d << 32)) - longint'(b) * 65536;
        if (num > 0) begin
          q = 64'(num) / (64'd2 * 64'(longint'(a)));
          e.radius = (q > 64'(RADIUS_FULL)) ? RADIUS_FULL : q[31:0];
        end
      end
    end
    return e;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    $display("mismatch %s: got %h, expected %h at cycle %0d", what, got, want, cycle_count);
  endtask

  // result checker
  always @(posedge clk) begin
    extent_t want;
    if (!rst && extent.valid && extent.ready) begin
      if (pending_extents.size() == 0) begin
        report_mismatch("unexpected word", extent.radius, 32'd0);
      end else begin
        want = pending_extents.pop_front();
        if (extent.radius !== want.radius)
          report_mismatch("radius", extent.radius, want.radius);
        if (extent.infinite_range !== want.infinite_range)
          report_mismatch("infinite_range", 32'(extent.infinite_range),
                          32'(want.infinite_range));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: random stalls, long hold-off on request
  initial begin
    int n;
    extent.ready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
      end else begin
        n = idle_free ? 0 : $urandom_range(0, 12);
      end
      if (n > 0) begin
        extent.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      extent.ready <= 1'b1;
      do @(posedge clk); while (!(extent.valid && extent.ready));
    end
  end

  task automatic send_light(logic [15:0] r, logic [15:0] g, logic [15:0] bl,
                            logic [31:0] c, logic [31:0] b, logic [31:0] a);
    int gap;
    extent_t e;
    gap = idle_free ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      light.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    light.valid          <= 1'b1;
    light.red_level      <= r;
    light.green_level    <= g;
    light.blue_level     <= bl;
    light.constant_term  <= c;
    light.linear_term    <= b;
    light.quadratic_term <= a;
    do @(posedge clk); while (!(light.valid && light.ready));
    e = predict_extent(r, g, bl, c, b, a);
    pending_extents.insert(pending_extents.size(), e);
    light_count++;
    if (e.infinite_range) infinite_count++;
    else if (e.radius == RADIUS_FULL) saturated_count++;
    else if (e.radius == 0) zero_count++;
  endtask

  task automatic end_burst();
    light.valid <= 1'b0;
    wait (pending_extents.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(logic [15:0] v);
    end_burst();
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    inv_threshold = v;
  endtask

  task automatic send_random_light(bit wild);
    logic [31:0] c, b, a;
    int kind;
    kind = $urandom_range(0, 9);
    c = $urandom_range(0, 1) ? $urandom_range(0, 32'h0040_0000)
                             : -$urandom_range(0, 32'h0040_0000);
    b = $urandom_range(0, 32'h0002_0000) - 32'h0000_4000;
    a = $urandom_range(1, 32'h0000_4000);
    if (wild || kind == 0) begin
      c = $urandom();
      b = $urandom();
      a = $urandom();
    end else if (kind <= 2) begin
      a = 32'd0;
    end else if (kind == 3) begin
      a = -$urandom_range(1, 32'h7FFF_FFFF);
    end else if (kind == 4) begin
      c = $urandom_range(32'h0100_0000, 32'h7FFF_FFFF);
    end
    send_light(16'($urandom()), 16'($urandom()), 16'($urandom()), c, b, a);
  endtask

  task automatic test_directed();
    send_light(16'h0, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0);
    send_light(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0, 32'h1, 32'h0);
    send_light(16'hFFFF, 16'h0, 16'h0, 32'h0, 32'h0001_0000, 32'h0);
    send_light(16'h0, 16'hFFFF, 16'h0, 32'h7FFF_FFFF, 32'h0001_0000, 32'h0);
    send_light(16'h0, 16'h0, 16'hFFFF, 32'h0, 32'hFFFF_FFFF, 32'h0);
    send_light(16'h8000, 16'h8000, 16'h8000, 32'h0, 32'h8000_0000, 32'h0);
    send_light(16'h8000, 16'h8000, 16'h8000, 32'h0, 32'h0, 32'hFFFF_FFFF);
    send_light(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0, 32'h0, 32'h8000_0000);
    send_light(16'h1000, 16'h1000, 16'h1000, 32'h7FFF_FFFF, 32'h1, 32'h1);
    send_light(16'h1000, 16'h1000, 16'h1000, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF);
    send_light(16'h0, 16'h0, 16'h0, 32'h0, 32'h0001_0000, 32'h0001_0000);
    send_light(16'h0, 16'h0, 16'h0, 32'h8000_0000, 32'h8000_0000, 32'h1);
    send_light(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_light(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1);
    send_light(16'h4000, 16'h4000, 16'h4000, 32'h0001_0000, 32'h0, 32'h0001_0000);
    send_light(16'hFFFF, 16'h0, 16'hFFFF, 32'h0, 32'h0, 32'h1);
    send_light(16'h1234, 16'h5678, 16'h9ABC, 32'hFFF0_0000, 32'h0000_8000, 32'h0000_0100);
    end_burst();
  endtask

  task automatic test_thresholds();
    logic [15:0] settings[4];
    settings = '{16'd1, 16'd65535, 16'd2, 16'd255};
    foreach (settings[i]) begin
      write_threshold(settings[i]);
      repeat (30) send_random_light(1'b0);
      send_light(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0, 32'h0001_0000, 32'h0);
      send_light(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0, 32'h0, 32'h0000_0001);
    end
    end_burst();
  endtask

  task automatic test_backpressure();
    idle_free = 1'b1;
    hold_request = 300;
    repeat (200) send_random_light(1'b0);
    idle_free = 1'b0;
    end_burst();
  endtask

  task automatic test_random();
    for (int i = 0; i < 800; i++) begin
      if (i % 200 == 0) write_threshold(16'($urandom_range(1, 65535)));
      idle_free = ((i / 50) % 4 == 3);
      send_random_light($urandom_range(0, 3) == 0);
    end
    idle_free = 1'b0;
    end_burst();
  endtask

  initial begin
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    light.valid = 1'b0;
    light.red_level = '0;
    light.green_level = '0;
    light.blue_level = '0;
    light.constant_term = '0;
    light.linear_term = '0;
    light.quadratic_term = '0;
    inv_threshold = ler_pkg::THR_RESET;
    mismatch_count = 0;
    cycle_count = 0;
    light_count = 0;
    infinite_count = 0;
    saturated_count = 0;
    zero_count = 0;
    idle_free = 1'b0;
    hold_request = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_thresholds();
    test_backpressure();
    test_random();
    $display("%0d lights over several thresholds: %0d infinite, %0d saturated, %0d zero",
             light_count, infinite_count, saturated_count, zero_count);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[light_extinction_radius_top.f]
+incdir+rtl
rtl/ler_pkg.sv
rtl/ler_light_if.sv
rtl/light_extinction_radius_top.sv
tb/sv/light_extinction_radius_top_tb.sv
